FILE: rtl/lge_pkg.sv
// ----------------------------------------------------------------------------
// Life grid package
// Grid geometry, field widths, command codes and shared types for the
// B3/S23 life grid engine.
// ----------------------------------------------------------------------------
package lge_pkg;

	localparam int GRID_W = 64;
	localparam int GRID_H = 64;

	localparam int MODE_W    = 2;
	localparam int X_W       = 6;
	localparam int Y_W       = 6;
	localparam int POP_OUT_W = 13;
	localparam int GEN_W     = 32;

	localparam int COL_W     = $clog2(GRID_W);
	localparam int ROW_W     = $clog2(GRID_H);
	localparam int CELLS     = GRID_W * GRID_H;
	localparam int POP_W     = $clog2(CELLS + 1);
	localparam int RPOP_W    = $clog2(GRID_W + 1);
	localparam int GRP_N     = (GRID_W + 7) / 8;
	localparam int GRP_CNT_W = 4;
	localparam int POP_MAX   = (1 << POP_OUT_W) - 1;
	localparam int CMP_W     = (POP_W > POP_OUT_W) ? POP_W : POP_OUT_W;

	localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;

	typedef logic [GRID_W-1:0] row_t;
	typedef logic [GRP_N-1:0][GRP_CNT_W-1:0] grp_cnt_t;

	// Per-cycle control for the rule unit during a sweep.
	typedef struct packed {
		logic             step;
		logic             hit;
		logic             set_val;
		logic [COL_W-1:0] col;
	} rule_ctl_t;

	// Population as reported on the result channel, clamped to the field.
	function automatic logic [POP_OUT_W-1:0] pop_sat(input logic [POP_W-1:0] v);
		logic [CMP_W-1:0] w;
		w = CMP_W'(v);
		if (w > CMP_W'(POP_MAX)) begin
			return POP_OUT_W'(POP_MAX);
		end
		return POP_OUT_W'(w);
	endfunction

endpackage

FILE: rtl/lge_if.sv
// ----------------------------------------------------------------------------
// Life grid channels
// Valid/ready channels for commands into and results out of the engine.
// ----------------------------------------------------------------------------
interface lge_in_if;
	logic                         valid;
	logic                         ready;
	logic [lge_pkg::MODE_W-1:0]   mode;
	logic [lge_pkg::X_W-1:0]      cell_x;
	logic [lge_pkg::Y_W-1:0]      cell_y;

	modport source (output valid, output mode, output cell_x, output cell_y, input ready);
	modport sink (input valid, input mode, input cell_x, input cell_y, output ready);
endinterface

interface lge_out_if;
	logic                          valid;
	logic                          ready;
	logic [lge_pkg::POP_OUT_W-1:0] population;
	logic [lge_pkg::GEN_W-1:0]     generation_count;

	modport source (output valid, output population, output generation_count, input ready);
	modport sink (input valid, input population, input generation_count, output ready);
endinterface

FILE: rtl/life_grid_generation_engine_unit.sv
// ----------------------------------------------------------------------------
// Life grid generation engine
// Bounded B3/S23 life grid with cell edits, generation steps, population and
// generation count per command.
// ----------------------------------------------------------------------------
// The grid lives in a circular chain of GRID_H row cells. Every command,
// edit or step alike, rotates the whole chain once through a single rule
// unit, one row per cycle, recomputing each row and recounting the live
// cells. A new command is taken the cycle after the result is loaded, so
// the engine takes no new command before the last one is through, and the
// row sweep sets the command rate. The result register holds a finished
// beat while the next command is already being worked on. An unused mode
// code sweeps the grid unchanged and reports the current population and
// generation count.
module life_grid_generation_engine_unit (
	input logic      clk,
	input logic      arst_n,
	lge_in_if.sink   cmd,
	lge_out_if.source res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	localparam logic [lge_pkg::ROW_W-1:0] LAST_ROW = lge_pkg::ROW_W'(lge_pkg::GRID_H - 1);

	state_t                          state_q;
	logic [lge_pkg::MODE_W-1:0]      mode_q;
	logic [lge_pkg::X_W-1:0]         x_q;
	logic [lge_pkg::Y_W-1:0]         y_q;
	logic                            in_grid_q;
	logic [lge_pkg::ROW_W-1:0]       row_cnt_q;
	lge_pkg::row_t                   prev_q;
	lge_pkg::grp_cnt_t               grp_s1;
	logic                            pop_vld_s1;
	logic [lge_pkg::POP_W-1:0]       acc_q;
	logic [lge_pkg::POP_W-1:0]       live_q;
	logic [lge_pkg::GEN_W-1:0]       gen_q;
	logic                            res_vld_q;

	lge_pkg::row_t                   rows [lge_pkg::GRID_H];
	lge_pkg::row_t                   new_row;
	lge_pkg::row_t                   below;
	lge_pkg::grp_cnt_t               grp_cnt;
	lge_pkg::rule_ctl_t              ctl;
	logic [lge_pkg::RPOP_W-1:0]      row_pop;
	logic                            shift;
	logic                            accept;
	logic                            load;
	logic                            in_grid;

	assign shift   = (state_q == ST_SWEEP);
	assign accept  = cmd.valid && cmd.ready;
	assign load    = (state_q == ST_DONE) && (!res_vld_q || res.ready);
	assign in_grid = (int'(cmd.cell_x) < lge_pkg::GRID_W) &&
		(int'(cmd.cell_y) < lge_pkg::GRID_H);

	// Row 0 is the head of the chain; the rewritten row re-enters at the tail.
	for (genvar i = 0; i < lge_pkg::GRID_H; i++) begin : g_cell
		if (i == lge_pkg::GRID_H - 1) begin : g_tail
			lge_row_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (new_row),
				.row    (rows[i])
			);
		end else begin : g_body
			lge_row_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (shift),
				.d      (rows[i+1]),
				.row    (rows[i])
			);
		end
	end

	// On the last row of the sweep the cell behind the head already holds
	// the new top row, so the row below is taken as empty.
	assign below = (row_cnt_q == LAST_ROW) ? '0 : rows[1];

	assign ctl.step    = (mode_q == lge_pkg::MODE_STEP);
	assign ctl.hit     = (mode_q inside {lge_pkg::MODE_SET, lge_pkg::MODE_CLEAR}) &&
		in_grid_q && (row_cnt_q == lge_pkg::ROW_W'(y_q));
	assign ctl.set_val = (mode_q == lge_pkg::MODE_SET);
	assign ctl.col     = lge_pkg::COL_W'(x_q);

	lge_rule_unit u_rule (
		.above   (prev_q),
		.cur     (rows[0]),
		.below   (below),
		.ctl     (ctl),
		.nxt_row (new_row),
		.grp_cnt (grp_cnt)
	);

	always_comb begin
		row_pop = '0;
		for (int g = 0; g < lge_pkg::GRP_N; g++) begin
			row_pop = row_pop + lge_pkg::RPOP_W'(grp_s1[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= '0;
			x_q        <= '0;
			y_q        <= '0;
			in_grid_q  <= 1'b0;
			row_cnt_q  <= '0;
			prev_q     <= '0;
			grp_s1     <= '0;
			pop_vld_s1 <= 1'b0;
			acc_q      <= '0;
			live_q     <= '0;
			gen_q      <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			pop_vld_s1 <= shift;
			if (shift) begin
				grp_s1 <= grp_cnt;
			end
			if (pop_vld_s1) begin
				acc_q <= acc_q + lge_pkg::POP_W'(row_pop);
			end

			if (load) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q    <= cmd.mode;
						x_q       <= cmd.cell_x;
						y_q       <= cmd.cell_y;
						in_grid_q <= in_grid;
						row_cnt_q <= '0;
						prev_q    <= '0;
						acc_q     <= '0;
						state_q   <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					prev_q    <= rows[0];
					row_cnt_q <= row_cnt_q + 1'b1;
					if (row_cnt_q == LAST_ROW) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load) begin
						live_q <= acc_q;
						if ((mode_q == lge_pkg::MODE_STEP) && (acc_q != '0)) begin
							gen_q <= gen_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready            = (state_q == ST_IDLE);
	assign res.valid            = res_vld_q;
	assign res.population       = lge_pkg::pop_sat(live_q);
	assign res.generation_count = gen_q;

endmodule

FILE: rtl/lge_row_cell.sv
// ----------------------------------------------------------------------------
// Life grid row cell
// Holds one grid row and takes the row of its neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module lge_row_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  lge_pkg::row_t d,
	output lge_pkg::row_t row
);

	lge_pkg::row_t row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (shift) begin
			row_q <= d;
		end
	end

	assign row = row_q;

endmodule

FILE: rtl/lge_rule_unit.sv
// ----------------------------------------------------------------------------
// Life grid rule unit
// Computes the next value of the head row, by the B3/S23 rule from its two
// neighbor rows, by a single cell edit or unchanged; counts its live cells.
// ----------------------------------------------------------------------------
module lge_rule_unit (
	input  lge_pkg::row_t      above,
	input  lge_pkg::row_t      cur,
	input  lge_pkg::row_t      below,
	input  lge_pkg::rule_ctl_t ctl,
	output lge_pkg::row_t      nxt_row,
	output lge_pkg::grp_cnt_t  grp_cnt
);

	localparam int PAD_W = lge_pkg::GRP_N * 8;

	logic [lge_pkg::GRID_W+1:0] a_p;
	logic [lge_pkg::GRID_W+1:0] c_p;
	logic [lge_pkg::GRID_W+1:0] b_p;
	logic [PAD_W-1:0]           nxt_pad;

	// Zero padding on both sides makes cells beyond the edge count as dead.
	assign a_p = {1'b0, above, 1'b0};
	assign c_p = {1'b0, cur, 1'b0};
	assign b_p = {1'b0, below, 1'b0};

	always_comb begin
		logic [3:0] n;
		logic       life;
		n    = '0;
		life = 1'b0;
		for (int c = 0; c < lge_pkg::GRID_W; c++) begin
			n = 4'(a_p[c]) + 4'(a_p[c+1]) + 4'(a_p[c+2]) + 4'(c_p[c]) +
				4'(c_p[c+2]) + 4'(b_p[c]) + 4'(b_p[c+1]) + 4'(b_p[c+2]);
			life = (n == 4'd3) || (cur[c] && (n == 4'd2));
			if (ctl.step) begin
				nxt_row[c] = life;
			end else if (ctl.hit && (lge_pkg::COL_W'(c) == ctl.col)) begin
				nxt_row[c] = ctl.set_val;
			end else begin
				nxt_row[c] = cur[c];
			end
		end
	end

	assign nxt_pad = PAD_W'(nxt_row);

	always_comb begin
		logic [lge_pkg::GRP_CNT_W-1:0] cnt;
		cnt = '0;
		for (int g = 0; g < lge_pkg::GRP_N; g++) begin
			cnt = '0;
			for (int b = 0; b < 8; b++) begin
				cnt = cnt + lge_pkg::GRP_CNT_W'(nxt_pad[g*8+b]);
			end
			grp_cnt[g] = cnt;
		end
	end

endmodule

FILE: rtl/lge_chk.sv
// ----------------------------------------------------------------------------
// Life grid port checker
// Watches the engine's channels and flags behavior the engine never shows.
// ----------------------------------------------------------------------------
module lge_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [lge_pkg::POP_OUT_W-1:0] population,
	input logic [lge_pkg::GEN_W-1:0]     generation_count
);

	// The engine works on one command at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
	else $error("command accepted while the engine was busy");

	// The generation count only ever moves forward by one.
	a_gen_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(generation_count) |-> generation_count == $past(generation_count) + 1'b1)
	else $error("generation count moved by other than one");

	// A new population is only ever shown together with a result beat.
	a_pop_with_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(population) |-> res_valid)
	else $error("population changed without a result beat");

	// The population can never exceed the number of cells.
	a_pop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> int'(population) <= lge_pkg::CELLS)
	else $error("population exceeds the grid size");

	// A stalled result beat stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
	else $error("result beat withdrawn before it was taken");

endmodule

bind life_grid_generation_engine_unit lge_chk u_lge_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.population       (res.population),
	.generation_count (res.generation_count)
);
